// ===== rtl/ntxd_pkg.sv =====
// Shared types, phase codes and helper function for the name table deobfuscator.
// No dependencies; used by the decode stage and the top level.
package ntxd_pkg;

	localparam int BYTE_W  = 8;
	localparam int COUNT_W = 24;
	localparam int LEN_W   = 32;
	localparam int MOD_W   = 3;

	typedef enum logic [1:0] {
		PH_LEN  = 2'd0,
		PH_NAME = 2'd1,
		PH_TERM = 2'd2,
		PH_DONE = 2'd3
	} phase_t;

	typedef struct packed {
		logic              table_done;
		logic              entry_end;
		logic              is_name_byte;
		logic [BYTE_W-1:0] out_byte;
	} result_t;

	// residue mod 5 of a value below 512, by reciprocal multiply
	function automatic logic [MOD_W-1:0] mod5(input logic [8:0] x);
		logic [16:0] prod;
		logic [6:0]  q;
		logic [9:0]  r;
		prod = {8'd0, x} * 17'd205;
		q    = prod[16:10];
		r    = {1'b0, x} - ({3'd0, q} * 10'd5);
		return r[MOD_W-1:0];
	endfunction

endpackage

// ===== rtl/ntxd_decode.sv =====
// Entry parser and keystream for the name table deobfuscator.
// Holds the parse state; depends on ntxd_pkg.
module ntxd_decode import ntxd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  logic [BYTE_W-1:0]  in_byte,
	input  logic [COUNT_W-1:0] entry_count,
	output result_t            res
);

	phase_t             phase_q, phase_d;
	logic [1:0]         pos_q, pos_d;
	logic [COUNT_W-1:0] idx_q, idx_d;
	logic [23:0]        len_lo_q, len_lo_d;
	logic [LEN_W-1:0]   cnt_q, cnt_d;
	logic [BYTE_W-1:0]  key_q, key_d;
	logic [MOD_W-1:0]   m5_q, m5_d;
	logic [LEN_W-1:0]   full_len;
	logic [MOD_W-1:0]   m5_acc;
	phase_t             ph;

	assign full_len = {in_byte, len_lo_q};
	assign m5_acc   = mod5({1'b0, in_byte} + {6'd0, m5_q});

	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_q;
		idx_d    = idx_q;
		len_lo_d = len_lo_q;
		cnt_d    = cnt_q;
		key_d    = key_q;
		m5_d     = m5_q;
		res      = '0;
		res.out_byte = in_byte;
		ph = phase_q;
		if (phase_q == PH_LEN && pos_q == 2'd0 && idx_q >= entry_count)
			ph = PH_DONE;
		unique case (ph)
			PH_LEN: begin
				unique case (pos_q)
					2'd0: begin
						len_lo_d[7:0] = in_byte;
						m5_d = mod5({1'b0, in_byte});
						pos_d = 2'd1;
					end
					2'd1: begin
						len_lo_d[15:8] = in_byte;
						m5_d = m5_acc;
						pos_d = 2'd2;
					end
					2'd2: begin
						len_lo_d[23:16] = in_byte;
						m5_d = m5_acc;
						pos_d = 2'd3;
					end
					default: begin
						cnt_d = full_len;
						key_d = idx_q[BYTE_W-1:0] + {5'd0, m5_acc}
							+ {full_len[6:0], 1'b0};
						pos_d = 2'd0;
						phase_d = (full_len == '0) ? PH_TERM : PH_NAME;
					end
				endcase
			end
			PH_NAME: begin
				res.out_byte     = in_byte ^ key_q;
				res.is_name_byte = 1'b1;
				key_d = key_q + 8'd2;
				cnt_d = cnt_q - 32'd1;
				if (cnt_q == 32'd1)
					phase_d = PH_TERM;
			end
			PH_TERM: begin
				res.entry_end = 1'b1;
				idx_d   = idx_q + 24'd1;
				pos_d   = 2'd0;
				phase_d = PH_LEN;
			end
			default: begin
				res.table_done = 1'b1;
				phase_d = PH_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEN;
			pos_q   <= 2'd0;
			idx_q   <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			idx_q   <= idx_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			len_lo_q <= len_lo_d;
			cnt_q    <= cnt_d;
			key_q    <= key_d;
			m5_q     <= m5_d;
		end
	end

endmodule

// ===== rtl/name_table_xor_deobfuscator_unit.sv =====
// Name table deobfuscator: input register, decode stage and result register.
// Depends on ntxd_pkg and ntxd_decode.
//
// Usage: bytes of the decompressed name table enter on the s_ stream, one
// request per byte. Each entry is a 4-byte little-endian length, the name
// bytes, then one terminator. Every input request yields exactly one output
// request on the m_ stream: the byte (name bytes XOR-decoded) and three flags
// in m_tuser. cfg_we/cfg_wdata load the entry count; write it only while the
// block is idle.
// Input acceptance reaches m_tvalid through the input register and the result
// register. Throughput: one byte per cycle while m_tready stays high, set by
// the single decode stage between the input register and the result register.
// Reset clears the parse state, the entry index and both stage valids; the
// entry count returns to 1. When the receiver holds m_tready low, the result
// stays in place, one more byte waits in the input register, and s_tready
// then drops until the output moves.
module name_table_xor_deobfuscator_unit import ntxd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // [7:0] in_byte
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [7:0]         m_tdata,   // [7:0] out_byte
	output logic [2:0]         m_tuser,   // [0] is_name_byte, [1] entry_end, [2] table_done
	input  logic               cfg_we,
	input  logic [COUNT_W-1:0] cfg_wdata
);

	logic               valid_s1;
	logic [BYTE_W-1:0]  byte_s1;
	logic               valid_s2;
	result_t            res_s2;
	result_t            res;
	logic [COUNT_W-1:0] entry_count_q;
	logic               advance;
	logic               fire;

	assign advance  = !valid_s2 || m_tready;
	assign fire     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= 24'd1;
		end else if (cfg_we) begin
			entry_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (advance)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			byte_s1 <= s_tdata;
		if (fire)
			res_s2 <= res;
	end

	ntxd_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.in_byte     (byte_s1),
		.entry_count (entry_count_q),
		.res         (res)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = res_s2.out_byte;
	assign m_tuser  = {res_s2.table_done, res_s2.entry_end, res_s2.is_name_byte};

endmodule

// ===== rtl/ntxd_checker.sv =====
// Port-level checks for the name table deobfuscator, bound to the top level.
// Depends on ntxd_pkg and name_table_xor_deobfuscator_unit.
module ntxd_checker import ntxd_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               s_tready,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [7:0]         m_tdata,
	input logic [2:0]         m_tuser
);

	logic done_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_seen_q <= 1'b0;
		end else if (m_tvalid && m_tready && m_tuser[2]) begin
			done_seen_q <= 1'b1;
		end
	end

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot0(m_tuser))
		else $error("more than one result flag set");

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && done_seen_q) |-> m_tuser[2])
		else $error("table left the done state");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("output changed while stalled");

endmodule

bind name_table_xor_deobfuscator_unit ntxd_checker u_ntxd_checker (.*);
